// ===== hw/rtl/qte_pkg.sv =====
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;
    localparam int SQRT_STEPS        = 17;
    localparam int TERM_STAGES       = 3;

    localparam int TERM_W  = 21;
    localparam int CX_W    = 24;
    localparam int ANG_W   = 26;
    localparam int OUT_W   = 16;
    localparam int YAW_W   = 15;
    localparam int ROOT_W  = 17;
    localparam int REST_W  = 33;

    localparam int LIM_180 = 23040;
    localparam int LIM_90  = 11520;

    typedef struct packed {
        logic signed [TERM_W-1:0] sp;
        logic signed [TERM_W-1:0] cp;
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic signed [TERM_W-1:0] sy;
        logic                     sat_pos;
        logic                     sat_neg;
    } t_terms;

    typedef struct packed {
        logic sat_pos;
        logic sat_neg;
    } t_yflags;

    // floor-shifted value saturated to the term range
    function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd1048575;
        lo = -36'sd1048576;
        if (v > hi) begin
            return TERM_W'(hi);
        end else if (v < lo) begin
            return TERM_W'(lo);
        end
        return v[TERM_W-1:0];
    endfunction

    // atan(2^-i) in degrees, Q.16
    function automatic logic [21:0] atan_q16(input int i);
        unique case (i)
            0:  return 22'd2949120;
            1:  return 22'd1740967;
            2:  return 22'd919879;
            3:  return 22'd466945;
            4:  return 22'd234379;
            5:  return 22'd117304;
            6:  return 22'd58666;
            7:  return 22'd29335;
            8:  return 22'd14668;
            9:  return 22'd7334;
            10: return 22'd3667;
            11: return 22'd1833;
            12: return 22'd917;
            13: return 22'd458;
            14: return 22'd229;
            15: return 22'd115;
            16: return 22'd57;
            17: return 22'd29;
            18: return 22'd14;
            19: return 22'd7;
            20: return 22'd4;
            21: return 22'd2;
            22: return 22'd1;
            default: return 22'd0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/quaternion_to_euler_angles_core.sv =====
// Quaternion to Euler angles.
// Slave channel: one quaternion per request, tdata = {z, y, x, w}, each
// signed Q2.14. Master channel: one result per request, tdata holds yaw
// (Q8.7, 15 bits), pitch and roll (Q9.7, 16 bits each).
// Pitch and roll are atan2 of the rotation terms; yaw is asin of its sine
// term, taken as atan2(s, sqrt(1 - s^2)) and clamped to +-90 degrees once
// the sine magnitude reaches one.
// Pipeline, from input acceptance to o_m_tvalid: the product and
// saturated-term registers, the integer square root steps, a pre-rotation
// register, the CORDIC rotation registers (N = min(CORDIC_STAGES, 24)
// rotations) and a rounding register, then the output register.
// Throughput: one quaternion per cycle unless frozen; every stage is fully pipelined.
// A two-entry output (output register plus skid register) keeps taking
// input while one result waits; the pipeline freezes only when both are
// full, and nothing is lost or repeated.
// Reset clears all valid bits and empties the output; data registers keep
// whatever they held.
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // yaw_deg, pitch_deg, roll_deg, 1 pad bit
);

    localparam int NC  = (CORDIC_STAGES > qte_pkg::CORDIC_MAX) ?
                         qte_pkg::CORDIC_MAX : CORDIC_STAGES;
    localparam int LAT = qte_pkg::TERM_STAGES + qte_pkg::SQRT_STEPS + NC + 2;

    logic                 en;
    logic [LAT-1:0]       r_vld;
    logic                 r_out_valid, r_skid_valid;
    logic [46:0]          r_out_data, r_skid_data;

    qte_pkg::t_terms      terms, sq_side;
    logic [qte_pkg::REST_W-1:0] rest;
    logic [qte_pkg::ROOT_W-1:0] root;
    qte_pkg::t_yflags     yf_in, yf_out;
    logic signed [qte_pkg::OUT_W-1:0] yaw_a, pitch_a, roll_a;
    logic [0:0]           side_p, side_r;
    logic signed [qte_pkg::YAW_W-1:0] yaw_f;
    logic [46:0]          p_data;

    assign en = !r_skid_valid;
    assign o_s_tready = en;

    qte_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (i_s_tdata[15:0]),
        .i_x     (i_s_tdata[31:16]),
        .i_y     (i_s_tdata[47:32]),
        .i_z     (i_s_tdata[63:48]),
        .o_terms (terms),
        .o_rest  (rest)
    );

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (rest),
        .i_side (terms),
        .o_root (root),
        .o_side (sq_side)
    );

    assign yf_in.sat_pos = sq_side.sat_pos;
    assign yf_in.sat_neg = sq_side.sat_neg;

    qte_cordic #(.STAGES(NC), .LIM(qte_pkg::LIM_90), .SIDE_W($bits(qte_pkg::t_yflags)))
    u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_side.sy),
        .i_x     (qte_pkg::TERM_W'({1'b0, root})),
        .i_side  (yf_in),
        .o_angle (yaw_a),
        .o_side  (yf_out)
    );

    qte_cordic #(.STAGES(NC), .LIM(qte_pkg::LIM_180), .SIDE_W(1)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_side.sp),
        .i_x     (sq_side.cp),
        .i_side  (1'b0),
        .o_angle (pitch_a),
        .o_side  (side_p)
    );

    qte_cordic #(.STAGES(NC), .LIM(qte_pkg::LIM_180), .SIDE_W(1)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (sq_side.sr),
        .i_x     (sq_side.cr),
        .i_side  (side_p),
        .o_angle (roll_a),
        .o_side  (side_r)
    );

    always_comb begin
        if (yf_out.sat_pos) begin
            yaw_f = qte_pkg::YAW_W'(qte_pkg::LIM_90);
        end else if (yf_out.sat_neg) begin
            yaw_f = -qte_pkg::YAW_W'(qte_pkg::LIM_90);
        end else begin
            yaw_f = yaw_a[qte_pkg::YAW_W-1:0];
        end
        p_data = {roll_a, pitch_a, yaw_f};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_m_tready) begin
            // hold the waiting result, park the next one
            if (en && r_vld[LAT-1]) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= en && r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_m_tready) begin
            if (en && r_vld[LAT-1]) begin
                r_skid_data <= p_data;
            end
        end else if (r_skid_valid) begin
            r_out_data <= r_skid_data;
        end else if (en && r_vld[LAT-1]) begin
            r_out_data <= p_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_data};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !o_s_tready)
        else $error("input accepted while skid register full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid register did not move to output");

    a_side_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] |-> (side_r == 1'b0))
        else $error("pitch/roll side band corrupted");

endmodule

// ===== hw/rtl/qte_terms.sv =====
module qte_terms (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_w,
    input  logic signed [15:0]   i_x,
    input  logic signed [15:0]   i_y,
    input  logic signed [15:0]   i_z,
    output qte_pkg::t_terms      o_terms,
    output logic [qte_pkg::REST_W-1:0] o_rest
);

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    qte_pkg::t_terms    r_t2;
    qte_pkg::t_terms    r_t3;
    logic [qte_pkg::REST_W-1:0] r_rest;

    logic signed [32:0] n_sps, n_sys, n_srs, n_cps, n_crs;
    logic signed [35:0] n_cpf, n_crf;
    qte_pkg::t_terms    n_t2;
    qte_pkg::t_terms    n_t3;
    logic signed [16:0] n_sylo;
    logic signed [33:0] n_sq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
        end
    end

    always_comb begin
        n_sps = 33'(r_wx) + 33'(r_yz);
        n_sys = 33'(r_wy) - 33'(r_zx);
        n_srs = 33'(r_wz) + 33'(r_xy);
        n_cps = 33'(r_xx) + 33'(r_yy);
        n_crs = 33'(r_yy) + 33'(r_zz);
        n_cpf = 36'sh10000000 - (36'(n_cps) <<< 1);
        n_crf = 36'sh10000000 - (36'(n_crs) <<< 1);
        n_t2.sp = qte_pkg::sat_term(36'(n_sps) >>> 11);
        n_t2.sy = qte_pkg::sat_term(36'(n_sys) >>> 11);
        n_t2.sr = qte_pkg::sat_term(36'(n_srs) >>> 11);
        n_t2.cp = qte_pkg::sat_term(n_cpf >>> 12);
        n_t2.cr = qte_pkg::sat_term(n_crf >>> 12);
        n_t2.sat_pos = 1'b0;
        n_t2.sat_neg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2 <= n_t2;
        end
    end

    always_comb begin
        n_sylo = r_t2.sy[16:0];
        n_sq   = n_sylo * n_sylo;
        n_t3         = r_t2;
        n_t3.sat_pos = (r_t2.sy >= 21'sd65536);
        n_t3.sat_neg = (r_t2.sy <= -21'sd65536);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t3 <= n_t3;
            if ((r_t2.sy < 21'sd65536) && (r_t2.sy > -21'sd65536)) begin
                r_rest <= 33'h100000000 - n_sq[32:0];
            end else begin
                r_rest <= '0;
            end
        end
    end

    assign o_terms = r_t3;
    assign o_rest  = r_rest;

endmodule

// ===== hw/rtl/qte_isqrt.sv =====
module qte_isqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [qte_pkg::REST_W-1:0]   i_val,
    input  qte_pkg::t_terms              i_side,
    output logic [qte_pkg::ROOT_W-1:0]   o_root,
    output qte_pkg::t_terms              o_side
);

    localparam int N = qte_pkg::SQRT_STEPS;

    logic [34:0]                 r_rem  [1:N];
    logic [qte_pkg::ROOT_W-1:0]  r_root [1:N];
    qte_pkg::t_terms             r_side [1:N];

    // one result bit per stage, from the top bit down
    for (genvar j = 0; j < N; j++) begin : g_step
        localparam int K = N - 1 - j;
        logic [34:0]                n_t;
        logic [34:0]                n_rem;
        logic [qte_pkg::ROOT_W-1:0] n_root;
        qte_pkg::t_terms            n_side;
        if (j == 0) begin : g_first
            assign n_rem  = 35'(i_val);
            assign n_root = '0;
            assign n_side = i_side;
        end else begin : g_next
            assign n_rem  = r_rem[j];
            assign n_root = r_root[j];
            assign n_side = r_side[j];
        end
        always_comb begin
            n_t = ({18'd0, n_root} << (K + 1)) | (35'd1 << (2 * K));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j+1] <= n_side;
                if (n_rem >= n_t) begin
                    r_rem[j+1]  <= n_rem - n_t;
                    r_root[j+1] <= n_root | (qte_pkg::ROOT_W'(1) << K);
                end else begin
                    r_rem[j+1]  <= n_rem;
                    r_root[j+1] <= n_root;
                end
            end
        end
    end

    assign o_root = r_root[N];
    assign o_side = r_side[N];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int LIM    = qte_pkg::LIM_180,
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [qte_pkg::TERM_W-1:0] i_y,
    input  logic signed [qte_pkg::TERM_W-1:0] i_x,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic signed [qte_pkg::OUT_W-1:0]  o_angle,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int CW = qte_pkg::CX_W;
    localparam int AW = qte_pkg::ANG_W;

    logic signed [CW-1:0] r_x [0:STAGES];
    logic signed [CW-1:0] r_y [0:STAGES];
    logic signed [AW-1:0] r_z [0:STAGES];
    logic                 r_zf [0:STAGES];
    logic [SIDE_W-1:0]    r_sd [0:STAGES];
    logic signed [qte_pkg::OUT_W-1:0] r_out;
    logic [SIDE_W-1:0]    r_sdo;

    logic signed [CW-1:0] n_x, n_y;
    logic signed [AW-1:0] n_q;

    // turn a vector in the left half plane by 180 degrees
    always_comb begin
        n_x = CW'(i_x);
        n_y = CW'(i_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zf[0] <= (i_x == '0) && (i_y == '0);
            r_sd[0] <= i_side;
            if (i_x < 0) begin
                r_x[0] <= -n_x;
                r_y[0] <= -n_y;
                r_z[0] <= (i_y >= 0) ? AW'(180 * 65536) : -AW'(180 * 65536);
            end else begin
                r_x[0] <= n_x;
                r_y[0] <= n_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [AW-1:0] ATN = AW'(qte_pkg::atan_q16(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[i+1] <= r_zf[i];
                r_sd[i+1] <= r_sd[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATN;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATN;
                end
            end
        end
    end

    always_comb begin
        n_q = (r_z[STAGES] + AW'(256)) >>> 9;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sdo <= r_sd[STAGES];
            if (r_zf[STAGES]) begin
                r_out <= '0;
            end else if (n_q > AW'(LIM)) begin
                r_out <= qte_pkg::OUT_W'(LIM);
            end else if (n_q < -AW'(LIM)) begin
                r_out <= -qte_pkg::OUT_W'(LIM);
            end else begin
                r_out <= n_q[qte_pkg::OUT_W-1:0];
            end
        end
    end

    assign o_angle = r_out;
    assign o_side  = r_sdo;

endmodule
